// ----- src/mccs_pkg.sv -----
package mccs_pkg;

    // fixed field widths
    localparam int COIN_W = 10;
    localparam int AMT_W  = 10;
    localparam int BEST_W = 11;

    // marks a table entry that no coin combination reaches
    localparam logic [BEST_W-1:0] UNREACH = 11'h7FF;

    // command codes
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SOLVE  = 2'd2
    } t_cmd;

    // solve sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // solve request from the command decode
    typedef struct packed {
        logic             start;
        logic [AMT_W-1:0] amount;
    } t_solve_req;

endpackage

// ----- src/mccs_ram.sv -----
module mccs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/mccs_fill.sv -----
module mccs_fill #(
    parameter int MAX_AMOUNT = 1023,
    parameter int MAX_COINS  = 16,
    parameter int TAW        = $clog2(MAX_AMOUNT + 1),
    parameter int CIW        = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1,
    parameter int CCW        = $clog2(MAX_COINS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mccs_pkg::t_solve_req          i_req,
    input  logic [CCW-1:0]                i_coin_count,
    output logic                          o_busy,
    output logic [CIW-1:0]                o_coin_raddr,
    input  logic [mccs_pkg::COIN_W-1:0]   i_coin_rdata,
    output logic                          o_tab_we,
    output logic [TAW-1:0]                o_tab_waddr,
    output logic [mccs_pkg::BEST_W-1:0]   o_tab_wdata,
    output logic [TAW-1:0]                o_tab_raddr,
    input  logic [mccs_pkg::BEST_W-1:0]   i_tab_rdata,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mccs_pkg::AMT_W-1:0]    o_min_coins,
    output logic                          o_no_solution
);

    mccs_pkg::t_state r_state, n_state;

    logic [mccs_pkg::AMT_W-1:0]  r_t, n_t;
    logic [mccs_pkg::AMT_W-1:0]  r_target, n_target;
    logic [CCW-1:0]              r_k, n_k;
    logic [mccs_pkg::BEST_W-1:0] r_best, n_best;
    logic                        r_b_vld, n_b_vld;
    logic                        r_b_last, n_b_last;
    logic                        r_c_vld, n_c_vld;
    logic                        r_c_use, n_c_use;
    logic                        r_c_last, n_c_last;
    logic                        r_out_vld, n_out_vld;
    logic [mccs_pkg::AMT_W-1:0]  r_out_cnt, n_out_cnt;
    logic                        r_out_nosol, n_out_nosol;

    logic                        a_last;
    logic                        b_use;
    logic [mccs_pkg::BEST_W-1:0] cand;
    logic [mccs_pkg::BEST_W-1:0] best_row;
    logic                        over_max;

    // issue stage: coin index for the current row
    assign o_coin_raddr = CIW'(r_k);
    assign a_last       = (r_k + CCW'(1)) == i_coin_count;

    // coin stage: coin fits the row, fetch table at row minus coin
    assign b_use       = (i_coin_rdata != '0) && (i_coin_rdata <= r_t);
    assign o_tab_raddr = TAW'(r_t - i_coin_rdata);

    // table stage: running minimum of the row
    assign cand     = i_tab_rdata + mccs_pkg::BEST_W'(1);
    assign best_row = (r_c_vld && r_c_use && (i_tab_rdata != mccs_pkg::UNREACH) &&
                       (cand < r_best)) ? cand : r_best;

    assign over_max = 32'(i_req.amount) > 32'(MAX_AMOUNT);

    // next state, row control and result word
    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_target    = r_target;
        n_k         = r_k;
        n_best      = r_c_vld ? best_row : r_best;
        n_b_vld     = (r_state == mccs_pkg::ST_SCAN);
        n_b_last    = a_last;
        n_c_vld     = r_b_vld;
        n_c_use     = b_use;
        n_c_last    = r_b_last;
        n_out_vld   = r_out_vld && i_stall;
        n_out_cnt   = r_out_cnt;
        n_out_nosol = r_out_nosol;
        o_tab_we    = 1'b0;
        o_tab_waddr = TAW'(r_t);
        o_tab_wdata = best_row;
        case (r_state)
            mccs_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    n_target = i_req.amount;
                    if (over_max || ((i_req.amount != '0) && (i_coin_count == '0))) begin
                        n_best  = mccs_pkg::UNREACH;
                        n_state = mccs_pkg::ST_FIN;
                    end else if (i_req.amount == '0) begin
                        n_best  = '0;
                        n_state = mccs_pkg::ST_FIN;
                    end else begin
                        n_state = mccs_pkg::ST_INIT;
                    end
                end
            end
            mccs_pkg::ST_INIT: begin
                // entry zero needs no coins
                o_tab_we    = 1'b1;
                o_tab_waddr = '0;
                o_tab_wdata = '0;
                n_t         = mccs_pkg::AMT_W'(1);
                n_k         = '0;
                n_best      = mccs_pkg::UNREACH;
                n_state     = mccs_pkg::ST_SCAN;
            end
            mccs_pkg::ST_SCAN: begin
                n_k = r_k + CCW'(1);
                if (a_last) begin
                    n_state = mccs_pkg::ST_DRAIN;
                end
            end
            mccs_pkg::ST_DRAIN: begin
                // row done once the last coin leaves the table stage
                if (r_c_vld && r_c_last) begin
                    o_tab_we = 1'b1;
                    if (r_t == r_target) begin
                        n_best  = best_row;
                        n_state = mccs_pkg::ST_FIN;
                    end else begin
                        n_best  = mccs_pkg::UNREACH;
                        n_t     = r_t + mccs_pkg::AMT_W'(1);
                        n_k     = '0;
                        n_state = mccs_pkg::ST_SCAN;
                    end
                end
            end
            mccs_pkg::ST_FIN: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld = 1'b1;
                    if (r_best == mccs_pkg::UNREACH) begin
                        n_out_cnt   = '0;
                        n_out_nosol = 1'b1;
                    end else begin
                        n_out_cnt   = r_best[mccs_pkg::AMT_W-1:0];
                        n_out_nosol = 1'b0;
                    end
                    n_state = mccs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mccs_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mccs_pkg::ST_IDLE;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b_vld   <= n_b_vld;
            r_c_vld   <= n_c_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_target    <= n_target;
        r_k         <= n_k;
        r_best      <= n_best;
        r_b_last    <= n_b_last;
        r_c_use     <= n_c_use;
        r_c_last    <= n_c_last;
        r_out_cnt   <= n_out_cnt;
        r_out_nosol <= n_out_nosol;
    end

    assign o_busy        = (r_state != mccs_pkg::ST_IDLE);
    assign o_valid       = r_out_vld;
    assign o_min_coins   = r_out_cnt;
    assign o_no_solution = r_out_nosol;

endmodule

// ----- src/min_coin_change_solver.sv -----
// channel | valid   | stall   | word
// input   | i_valid | o_stall | i_cmd, i_coin_value, i_amount
// output  | o_valid | i_stall | o_min_coins, o_no_solution
//
// clear and append never stall the input
// during a solve each table row reads every listed coin through the coin memory,
// then the table memory, then writes the row
// amount zero, an empty list or an amount beyond the table skips the table fill
// reset is synchronous and empties the coin list; no memory clearing pass
// a finished result waits in the output register while i_stall is high;
// clear and append are still taken meanwhile
module min_coin_change_solver #(
    parameter int MAX_AMOUNT = 1023,
    parameter int MAX_COINS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_cmd,
    input  logic [mccs_pkg::COIN_W-1:0] i_coin_value,
    input  logic [mccs_pkg::AMT_W-1:0]  i_amount,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mccs_pkg::AMT_W-1:0]  o_min_coins,
    output logic                        o_no_solution
);

    localparam int TAW = $clog2(MAX_AMOUNT + 1);
    localparam int CIW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int CCW = $clog2(MAX_COINS + 1);

    logic [CCW-1:0]              r_coin_count, n_coin_count;
    logic                        in_acc;
    logic                        busy;
    logic                        coin_we;
    mccs_pkg::t_solve_req        req;
    logic [CIW-1:0]              coin_raddr;
    logic [mccs_pkg::COIN_W-1:0] coin_rdata;
    logic                        tab_we;
    logic [TAW-1:0]              tab_waddr;
    logic [TAW-1:0]              tab_raddr;
    logic [mccs_pkg::BEST_W-1:0] tab_wdata;
    logic [mccs_pkg::BEST_W-1:0] tab_rdata;

    assign o_stall = busy;
    assign in_acc  = i_valid && !busy;

    // command decode and coin list fill
    always_comb begin
        n_coin_count = r_coin_count;
        coin_we      = 1'b0;
        req.start    = 1'b0;
        req.amount   = i_amount;
        if (in_acc) begin
            case (i_cmd)
                mccs_pkg::CMD_CLEAR: begin
                    n_coin_count = '0;
                end
                mccs_pkg::CMD_APPEND: begin
                    if (r_coin_count < CCW'(MAX_COINS)) begin
                        coin_we      = 1'b1;
                        n_coin_count = r_coin_count + CCW'(1);
                    end
                end
                mccs_pkg::CMD_SOLVE: begin
                    req.start = 1'b1;
                end
                default: begin
                    n_coin_count = r_coin_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin_count <= '0;
        end else begin
            r_coin_count <= n_coin_count;
        end
    end

    // coin list memory
    mccs_ram #(
        .WIDTH (mccs_pkg::COIN_W),
        .DEPTH (MAX_COINS)
    ) u_coin_ram (
        .i_clk   (i_clk),
        .i_we    (coin_we),
        .i_waddr (CIW'(r_coin_count)),
        .i_wdata (i_coin_value),
        .i_raddr (coin_raddr),
        .o_rdata (coin_rdata)
    );

    // best count table memory
    mccs_ram #(
        .WIDTH (mccs_pkg::BEST_W),
        .DEPTH (MAX_AMOUNT + 1)
    ) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    // table fill sequencer and result register
    mccs_fill #(
        .MAX_AMOUNT (MAX_AMOUNT),
        .MAX_COINS  (MAX_COINS),
        .TAW        (TAW),
        .CIW        (CIW),
        .CCW        (CCW)
    ) u_fill (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_coin_count  (r_coin_count),
        .o_busy        (busy),
        .o_coin_raddr  (coin_raddr),
        .i_coin_rdata  (coin_rdata),
        .o_tab_we      (tab_we),
        .o_tab_waddr   (tab_waddr),
        .o_tab_wdata   (tab_wdata),
        .o_tab_raddr   (tab_raddr),
        .i_tab_rdata   (tab_rdata),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_min_coins   (o_min_coins),
        .o_no_solution (o_no_solution)
    );

endmodule

// ----- src/mccs_check.sv -----
module mccs_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [1:0]                  i_cmd,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [mccs_pkg::AMT_W-1:0]  o_min_coins,
    input logic                        o_no_solution
);

    // a stalled result word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_min_coins) && $stable(o_no_solution))
        else $error("stalled result word changed");

    // no solution always reports a zero count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_solution |-> o_min_coins == '0)
        else $error("no solution with nonzero count");

    // an accepted solve keeps the input stalled in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == mccs_pkg::CMD_SOLVE) |=> o_stall)
        else $error("solve did not occupy the block");

    // list edits never occupy the block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd != mccs_pkg::CMD_SOLVE) |=> !o_stall)
        else $error("list edit stalled the input");

    // reset leaves no result pending
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result pending after reset");

endmodule

bind min_coin_change_solver mccs_check u_mccs_check (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int MAX_AMOUNT = 1023;
    localparam int MAX_COINS  = 16;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one answer of a solve
    typedef struct {
        logic [mccs_pkg::AMT_W-1:0] min_coins;
        logic                       no_solution;
    } t_answer;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [1:0]                   i_cmd;
    logic [mccs_pkg::COIN_W-1:0]  i_coin_value;
    logic [mccs_pkg::AMT_W-1:0]   i_amount;
    logic                         o_valid;
    logic                         i_stall;
    logic [mccs_pkg::AMT_W-1:0]   o_min_coins;
    logic                         o_no_solution;

    // predicted coin list and fill table
    logic [mccs_pkg::COIN_W-1:0]  coin_list [MAX_COINS];
    int                           coin_total = 0;
    logic [mccs_pkg::BEST_W-1:0]  fewest_tab [MAX_AMOUNT+1];
    t_answer                      pending_answers [$];

    int  errors = 0;
    int  cycle_cnt = 0;
    bit  quiet = 1'b0;
    int  rx_wait = 0;
    int  rx_hold = 0;
    int  big_left = 4;

    // run statistics
    int  words_sent = 0;
    int  solves_sent = 0;
    int  unreach_sent = 0;
    int  big_solves = 0;
    int  appends_dropped = 0;
    int  answers_checked = 0;

    min_coin_change_solver #(
        .MAX_AMOUNT(MAX_AMOUNT),
        .MAX_COINS (MAX_COINS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_coin_value (i_coin_value),
        .i_amount     (i_amount),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_min_coins  (o_min_coins),
        .o_no_solution(o_no_solution)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // bottom-up fill of the fewest-coin table up to the target
    function automatic t_answer fewest_coins(logic [mccs_pkg::AMT_W-1:0] target);
        t_answer ans;
        int best;
        int prev;
        int c;
        fewest_tab[0] = '0;
        for (int t = 1; t <= int'(target); t++) begin
            best = int'(mccs_pkg::UNREACH);
            for (int k = 0; k < coin_total; k++) begin
                c = int'(coin_list[k]);
                if (c != 0 && c <= t) begin
                    prev = int'(fewest_tab[t - c]);
                    if (prev != int'(mccs_pkg::UNREACH) && prev + 1 < best) best = prev + 1;
                end
            end
            fewest_tab[t] = mccs_pkg::BEST_W'(best);
        end
        if (fewest_tab[target] == mccs_pkg::UNREACH) begin
            ans.min_coins = '0;
            ans.no_solution = 1'b1;
        end else begin
            ans.min_coins = fewest_tab[target][mccs_pkg::AMT_W-1:0];
            ans.no_solution = 1'b0;
        end
        return ans;
    endfunction

    // apply one accepted word to the predicted state
    function automatic void take_word(logic [1:0] cmd, logic [mccs_pkg::COIN_W-1:0] coin,
                                      logic [mccs_pkg::AMT_W-1:0] amt);
        t_answer ans;
        case (cmd)
            mccs_pkg::CMD_CLEAR: begin
                coin_total = 0;
            end
            mccs_pkg::CMD_APPEND: begin
                if (coin_total < MAX_COINS) begin
                    coin_list[coin_total] = coin;
                    coin_total++;
                end else begin
                    appends_dropped++;
                end
            end
            mccs_pkg::CMD_SOLVE: begin
                ans = fewest_coins(amt);
                pending_answers.push_back(ans);
                solves_sent++;
                if (ans.no_solution) unreach_sent++;
                if (amt > 63) big_solves++;
            end
            default: ;
        endcase
    endfunction

    // offer one word after a random gap and hold it until accepted
    task automatic send_word(logic [1:0] cmd, logic [mccs_pkg::COIN_W-1:0] coin,
                             logic [mccs_pkg::AMT_W-1:0] amt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_coin_value <= coin;
        i_amount     <= amt;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        take_word(cmd, coin, amt);
        words_sent++;
    endtask

    // stop offering, then wait for every expected answer
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // receiver: long hold-off, else stall for the drawn count of offered cycles
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            if (o_valid === 1'b1) rx_wait = rx_wait - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // check each accepted answer against the oldest prediction
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_answers.size() == 0) begin
                $error("answer with none expected: min_coins %0d no_solution %0d",
                       o_min_coins, o_no_solution);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (o_min_coins !== want.min_coins) begin
                    $error("min_coins: expected %0d, actual %0d",
                           want.min_coins, o_min_coins);
                    errors++;
                end
                if (o_no_solution !== want.no_solution) begin
                    $error("no_solution: expected %0d, actual %0d",
                           want.no_solution, o_no_solution);
                    errors++;
                end
            end
            rx_wait = quiet ? 0 : $urandom_range(0, 9);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // empty list: amount zero, largest amount, unused command
    task automatic test_empty_list();
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), '0);
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom),
                  mccs_pkg::AMT_W'(MAX_AMOUNT));
        send_word(CMD_UNUSED, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'($urandom));
    endtask

    // fill the list, including a zero coin and the largest coin, then overflow it
    task automatic test_full_list();
        int fill_vals [14] = '{6, 10, 15, 21, 28, 36, 45, 55, 66, 78, 91, 105, 120, 136};
        send_word(mccs_pkg::CMD_APPEND, '0, mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(1023), mccs_pkg::AMT_W'($urandom));
        foreach (fill_vals[i])
            send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(fill_vals[i]),
                      mccs_pkg::AMT_W'($urandom));
        // dropped: list already full
        send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(1), mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'(1));
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom),
                  mccs_pkg::AMT_W'(MAX_AMOUNT));
    endtask

    // greedy choice would use three coins here, the best is two
    task automatic test_non_greedy();
        send_word(mccs_pkg::CMD_CLEAR, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(4), mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(3), mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(1), mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'(6));
    endtask

    // receiver holds off while solves queue up, then the sender drains
    task automatic test_backpressure();
        quiet = 1'b1;
        send_word(mccs_pkg::CMD_CLEAR, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(2), mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(5), mccs_pkg::AMT_W'($urandom));
        rx_hold = 400;
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'(10));
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'(21));
        send_word(mccs_pkg::CMD_APPEND, mccs_pkg::COIN_W'(7), mccs_pkg::AMT_W'($urandom));
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'(15));
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'(3));
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'(40));
        wait_drained();
        quiet = 1'b0;
        send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'(1));
    endtask

    function automatic logic [mccs_pkg::COIN_W-1:0] pick_coin();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return mccs_pkg::COIN_W'($urandom);
        if (r == 1) return '0;
        return mccs_pkg::COIN_W'($urandom_range(1, 20));
    endfunction

    function automatic logic [mccs_pkg::AMT_W-1:0] pick_amount();
        if (big_left > 0 && $urandom_range(0, 19) == 0) begin
            big_left--;
            return mccs_pkg::AMT_W'($urandom);
        end
        if ($urandom_range(0, 9) == 0) return '0;
        return mccs_pkg::AMT_W'($urandom_range(1, 63));
    endfunction

    // random coin sets, each followed by a few solves, with some noise
    task automatic test_random(int target_words);
        int counted;
        int n_coins;
        int n_solves;
        counted = 0;
        while (counted < target_words) begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) != 0) begin
                send_word(mccs_pkg::CMD_CLEAR, mccs_pkg::COIN_W'($urandom),
                          mccs_pkg::AMT_W'($urandom));
                counted++;
            end
            n_coins = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18)
                                                   : $urandom_range(0, 5);
            for (int i = 0; i < n_coins; i++) begin
                send_word(mccs_pkg::CMD_APPEND, pick_coin(), mccs_pkg::AMT_W'($urandom));
                counted++;
            end
            n_solves = $urandom_range(1, 4);
            for (int i = 0; i < n_solves; i++) begin
                send_word(mccs_pkg::CMD_SOLVE, mccs_pkg::COIN_W'($urandom), pick_amount());
                counted++;
            end
            if ($urandom_range(0, 9) == 0)
                send_word(CMD_UNUSED, mccs_pkg::COIN_W'($urandom), mccs_pkg::AMT_W'($urandom));
            if ($urandom_range(0, 4) == 0) wait_drained();
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = mccs_pkg::CMD_CLEAR;
        i_coin_value = '0;
        i_amount     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_full_list();
        test_non_greedy();
        test_backpressure();
        test_random(60);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d words, %0d solves (%0d unreachable, %0d above amount 63)",
                 words_sent, solves_sent, unreach_sent, big_solves);
        $display("%0d answers checked, %0d appends dropped on a full list, %0d cycles",
                 answers_checked, appends_dropped, cycle_cnt);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- min_coin_change_solver.f -----
src/mccs_pkg.sv
src/mccs_ram.sv
src/mccs_fill.sv
src/min_coin_change_solver.sv
src/mccs_check.sv
sim/tb.sv
